// File: hdl/pcbf_pkg.sv
// Shared types and constants for the point cloud bounds fit block.
`timescale 1ns / 1ps

package pcbf_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned EXTENT_W   = 15;
  localparam int unsigned MARGIN_W   = 14;
  localparam int unsigned CFG_W      = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned PCBF_MAX_POINTS = 64;

  // Quotient bits of the rescale divider; the quotient never exceeds |window|.
  localparam int unsigned QBITS      = 15;
  localparam int unsigned DCNT_W     = $clog2(QBITS);

  localparam logic [EXTENT_W-1:0] EXTENT_RST = EXTENT_W'(16384);
  localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(461);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXTENT_X = 2'd0,
    CFG_EXTENT_Y = 2'd1,
    CFG_EXTENT_Z = 2'd2,
    CFG_MARGIN   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_FETCH,
    ST_DIFF,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic plan;
    logic fetch;
    logic diff;
    logic mul;
    logic div_load;
    logic div_step;
    logic emit;
  } pcbf_cmd_t;

  typedef struct packed {
    logic need_div;
    logic last_pt;
  } pcbf_status_t;

endpackage

// File: hdl/pcbf_axis.sv
// One axis lane: bounds tracking, fit plan, and the per-coordinate fit datapath.
`timescale 1ns / 1ps

module pcbf_axis
  import pcbf_pkg::*;
(
  input  logic                        clk_i,
  input  pcbf_cmd_t                   cmd_i,
  input  logic                        upd_i,
  input  logic                        first_i,
  input  logic signed [COORD_W-1:0]   pt_i,
  input  logic signed [COORD_W-1:0]   rd_pt_i,
  input  logic        [EXTENT_W-1:0]  extent_i,
  input  logic        [MARGIN_W-1:0]  margin_i,
  output logic                        need_div_o,
  output logic signed [COORD_W-1:0]   res_o
);

  localparam int unsigned SPAN_W = COORD_W + 1;
  localparam int unsigned OFF_W  = COORD_W + 2;
  localparam int unsigned SUM_W  = COORD_W + 3;
  localparam int unsigned PROD_W = SPAN_W + QBITS;
  localparam int unsigned DVS_W  = SPAN_W + QBITS - 1;

  typedef enum logic [1:0] {
    FIT_KEEP,
    FIT_SCALE,
    FIT_SHIFT
  } fit_mode_e;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] vmax;
    logic signed [SUM_W-1:0] vmin;
    vmax = SUM_W'(2**(COORD_W-1) - 1);
    vmin = -(SUM_W'(2**(COORD_W-1)));
    if (v > vmax) begin
      sat_coord = vmax[COORD_W-1:0];
    end else if (v < vmin) begin
      sat_coord = vmin[COORD_W-1:0];
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

  logic signed [COORD_W-1:0] min_q, max_q;

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      if (first_i || (pt_i < min_q)) min_q <= pt_i;
      if (first_i || (pt_i > max_q)) max_q <= pt_i;
    end
  end

  // Fit plan, taken once per set
  logic signed [SPAN_W-1:0] lo_s, hi_s, win_s, mn_s, mx_s;
  logic        [SPAN_W-1:0] span_d;
  logic signed [OFF_W-1:0]  off_d;
  logic        [QBITS-1:0]  winabs_d;
  logic                     in_window, over;
  fit_mode_e                mode_d;

  always_comb begin
    lo_s   = $signed({3'b000, margin_i});
    hi_s   = $signed({2'b00, extent_i}) - lo_s;
    win_s  = hi_s - lo_s;
    mn_s   = $signed({min_q[COORD_W-1], min_q});
    mx_s   = $signed({max_q[COORD_W-1], max_q});
    span_d = mx_s - mn_s;
    in_window = (mn_s >= lo_s) && (mx_s <= hi_s);
    over   = $signed({1'b0, span_d}) > $signed({win_s[SPAN_W-1], win_s});
    if (mn_s < lo_s) begin
      off_d = $signed({lo_s[SPAN_W-1], lo_s}) - $signed({mn_s[SPAN_W-1], mn_s});
    end else begin
      off_d = $signed({hi_s[SPAN_W-1], hi_s}) - $signed({mx_s[SPAN_W-1], mx_s});
    end
    winabs_d = win_s[SPAN_W-1] ? QBITS'(-win_s) : QBITS'(win_s);
    if (in_window) begin
      mode_d = FIT_KEEP;
    end else if (over) begin
      mode_d = FIT_SCALE;
    end else begin
      mode_d = FIT_SHIFT;
    end
  end

  fit_mode_e                mode_q;
  logic signed [OFF_W-1:0]  off_q;
  logic        [QBITS-1:0]  winabs_q;
  logic                     winneg_q;
  logic        [SPAN_W-1:0] span_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.plan) begin
      mode_q   <= mode_d;
      off_q    <= off_d;
      winabs_q <= winabs_d;
      winneg_q <= win_s[SPAN_W-1];
      span_q   <= span_d;
    end
  end

  // Per-coordinate datapath
  logic signed [COORD_W-1:0] p_q;
  logic        [SPAN_W-1:0]  d_q;
  logic signed [SUM_W-1:0]   sh_q;
  logic        [PROD_W-1:0]  prod_q;
  logic        [PROD_W-1:0]  rem_q;
  logic        [DVS_W-1:0]   dvs_q;
  logic        [QBITS-1:0]   quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      p_q  <= rd_pt_i;
      d_q  <= SPAN_W'($signed({rd_pt_i[COORD_W-1], rd_pt_i})
                      - $signed({min_q[COORD_W-1], min_q}));
      sh_q <= $signed({{3{rd_pt_i[COORD_W-1]}}, rd_pt_i})
              + $signed({off_q[OFF_W-1], off_q});
    end
    if (cmd_i.mul) begin
      prod_q <= d_q * winabs_q;
    end
    // Restoring division of (d*|win| + span/2) by span, one quotient bit per step
    if (cmd_i.div_load) begin
      rem_q <= prod_q + PROD_W'(span_q[SPAN_W-1:1]);
      dvs_q <= {span_q, {(QBITS-1){1'b0}}};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= PROD_W'(dvs_q)) begin
        rem_q <= rem_q - PROD_W'(dvs_q);
        quo_q <= {quo_q[QBITS-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QBITS-2:0], 1'b0};
      end
      dvs_q <= dvs_q >> 1;
    end
  end

  assign need_div_o = (mode_q == FIT_SCALE) && (span_q != '0);

  logic signed [COORD_W-1:0] sq;
  logic signed [SUM_W-1:0]   scale_sum;

  always_comb begin
    sq = winneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    if (span_q == '0) begin
      scale_sum = $signed({5'b00000, margin_i});
    end else begin
      scale_sum = $signed({5'b00000, margin_i}) + $signed({{3{sq[COORD_W-1]}}, sq});
    end
    unique case (mode_q)
      FIT_KEEP:  res_o = p_q;
      FIT_SCALE: res_o = sat_coord(scale_sum);
      FIT_SHIFT: res_o = sat_coord(sh_q);
      default:   res_o = p_q;
    endcase
  end

endmodule

// File: hdl/pcbf_datapath.sv
// Datapath: config registers, point memory, count, drop flag, axis lanes and result registers.
`timescale 1ns / 1ps

module pcbf_datapath
  import pcbf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = PCBF_MAX_POINTS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcbf_cmd_t                   cmd_i,
  output pcbf_status_t                status_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  input  logic signed [COORD_W-1:0]   in_x_i,
  input  logic signed [COORD_W-1:0]   in_y_i,
  input  logic signed [COORD_W-1:0]   in_z_i,
  output logic                        out_valid_o,
  output logic signed [COORD_W-1:0]   out_x_o,
  output logic signed [COORD_W-1:0]   out_y_o,
  output logic signed [COORD_W-1:0]   out_z_o,
  output logic                        out_last_o,
  output logic                        overflowed_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned WORD_W = 3 * COORD_W;

  logic [EXTENT_W-1:0] ext_q [3];
  logic [MARGIN_W-1:0] margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q[0] <= EXTENT_RST;
      ext_q[1] <= EXTENT_RST;
      ext_q[2] <= EXTENT_RST;
      margin_q <= MARGIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_EXTENT_X: ext_q[0] <= cfg_wdata_i[EXTENT_W-1:0];
        CFG_EXTENT_Y: ext_q[1] <= cfg_wdata_i[EXTENT_W-1:0];
        CFG_EXTENT_Z: ext_q[2] <= cfg_wdata_i[EXTENT_W-1:0];
        CFG_MARGIN:   margin_q <= cfg_wdata_i[MARGIN_W-1:0];
      endcase
    end
  end

  logic [CW-1:0] cnt_q;
  logic [AW-1:0] idx_q;
  logic          drop_q;
  logic          room, store, last_pt, set_done;

  assign room     = cnt_q < CW'(MAX_POINTS);
  assign store    = cmd_i.load && room;
  assign last_pt  = (CW'(idx_q) + CW'(1)) == cnt_q;
  assign set_done = cmd_i.emit && last_pt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      drop_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (set_done) begin
        cnt_q  <= '0;
        drop_q <= 1'b0;
      end else begin
        if (store) cnt_q <= cnt_q + CW'(1);
        if (cmd_i.load && !room) drop_q <= 1'b1;
      end
      if (cmd_i.plan) begin
        idx_q <= '0;
      end else if (cmd_i.emit) begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  logic [WORD_W-1:0] mem [MAX_POINTS];
  logic [WORD_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (store) mem[cnt_q[AW-1:0]] <= {in_z_i, in_y_i, in_x_i};
    if (cmd_i.fetch) rd_q <= mem[idx_q];
  end

  logic signed [COORD_W-1:0] pt_in [3];
  logic signed [COORD_W-1:0] res   [3];
  logic        [2:0]         need_div;

  assign pt_in[0] = in_x_i;
  assign pt_in[1] = in_y_i;
  assign pt_in[2] = in_z_i;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    pcbf_axis u_axis (
      .clk_i      (clk_i),
      .cmd_i      (cmd_i),
      .upd_i      (store),
      .first_i    (cnt_q == '0),
      .pt_i       (pt_in[a]),
      .rd_pt_i    ($signed(rd_q[a*COORD_W +: COORD_W])),
      .extent_i   (ext_q[a]),
      .margin_i   (margin_q),
      .need_div_o (need_div[a]),
      .res_o      (res[a])
    );
  end

  assign status_o.need_div = |need_div;
  assign status_o.last_pt  = last_pt;

  logic                      out_valid_q;
  logic signed [COORD_W-1:0] out_x_q, out_y_q, out_z_q;
  logic                      out_last_q, ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_x_q    <= res[0];
      out_y_q    <= res[1];
      out_z_q    <= res[2];
      out_last_q <= last_pt;
      ovf_q      <= drop_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_z_o      = out_z_q;
  assign out_last_o   = out_last_q;
  assign overflowed_o = ovf_q;

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($past(cnt_q) != '0))
    else $error("result emitted from an empty point set");

  a_set_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_done |=> ((cnt_q == '0) && !drop_q))
    else $error("point count or drop flag not cleared after final result");

endmodule

// File: hdl/pcbf_ctrl.sv
// Controller state machine: sequences loading, fit planning and per-point emission.
`timescale 1ns / 1ps

module pcbf_ctrl
  import pcbf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         in_last_i,
  input  pcbf_status_t status_i,
  output pcbf_cmd_t    cmd_o,
  output logic         busy_o
);

  ctrl_state_e       state_q, state_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    dcnt_d  = dcnt_q;
    unique case (state_q)
      ST_IDLE:  if (start_i && in_last_i) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_FETCH;
      ST_FETCH: state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_MUL;
      ST_MUL:   state_d = status_i.need_div ? ST_LOAD : ST_EMIT;
      ST_LOAD: begin
        state_d = ST_DIV;
        dcnt_d  = DCNT_W'(QBITS - 1);
      end
      ST_DIV: begin
        if (dcnt_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          dcnt_d = dcnt_q - DCNT_W'(1);
        end
      end
      ST_EMIT:  state_d = status_i.last_pt ? ST_IDLE : ST_FETCH;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    busy_o   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_SETUP: cmd_o.plan     = 1'b1;
      ST_FETCH: cmd_o.fetch    = 1'b1;
      ST_DIFF:  cmd_o.diff     = 1'b1;
      ST_MUL:   cmd_o.mul      = 1'b1;
      ST_LOAD:  cmd_o.div_load = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_EMIT:  cmd_o.emit     = 1'b1;
    endcase
  end

  a_div_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> status_i.need_div)
    else $error("divider stepping while no axis rescales");

  a_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(state_q == ST_EMIT))
    else $error("controller went idle without emitting the final point");

endmodule

// File: hdl/point_cloud_bounds_fit_core.sv
// Top level of the point cloud bounds fit block: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
//   Points enter on in_x_i/in_y_i/in_z_i/in_last_i and transfer at a clock
//   edge where start_i is high and busy_o is low; loading takes one cycle per
//   point. Up to MAX_POINTS points are stored; further points are dropped and
//   flag overflowed_o on every result of that set.
//   The point with in_last_i high starts emission: busy_o rises and each
//   stored point is shown, in arrival order, for exactly one cycle with
//   out_valid_o high. out_last_o marks the final one. The receiver cannot
//   stall, so the result registers simply hold until the next emission.
//   After the last point's transfer the controller runs SETUP for the set,
//   then for each stored point, one after another, FETCH, DIFF and MUL,
//   LOAD and DIV when an axis rescales, and EMIT; each axis lane has its own
//   restoring divider, which takes one quotient bit per cycle.
//   busy_o drops in the cycle the final result is shown, so a new set can
//   start right away. The cfg_* port writes extents and margin; write it
//   only while busy_o is low. Reset empties the point set, restores the
//   default configuration and clears the result strobe.

module point_cloud_bounds_fit_core
  import pcbf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = PCBF_MAX_POINTS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic signed [COORD_W-1:0]  in_x_i,
  input  logic signed [COORD_W-1:0]  in_y_i,
  input  logic signed [COORD_W-1:0]  in_z_i,
  input  logic                       in_last_i,
  output logic                       out_valid_o,
  output logic signed [COORD_W-1:0]  out_x_o,
  output logic signed [COORD_W-1:0]  out_y_o,
  output logic signed [COORD_W-1:0]  out_z_o,
  output logic                       out_last_o,
  output logic                       overflowed_o
);

  pcbf_cmd_t    cmd;
  pcbf_status_t status;

  pcbf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .in_last_i (in_last_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy_o)
  );

  pcbf_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_x_i       (in_x_i),
    .in_y_i       (in_y_i),
    .in_z_i       (in_z_i),
    .out_valid_o  (out_valid_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .out_last_o   (out_last_o),
    .overflowed_o (overflowed_o)
  );

endmodule
